// ===== design/ucs2_string_to_utf8_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// ucs2_string_to_utf8_decoder_core_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef UCS2_STRING_TO_UTF8_DECODER_CORE_ASSERT_SVH
`define UCS2_STRING_TO_UTF8_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define U2U8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u2u8 assertion failed");

// next-cycle implication
`define U2U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u2u8 assertion failed");

`endif

// ===== design/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u8_pkg
// Types and constants of the UCS-2 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] UNIT_REPL = 16'hFFFD;
	localparam logic [15:0] UNIT_NONE = 16'hFFFF;
	localparam logic [15:0] LIM_ONE   = 16'h0080;
	localparam logic [15:0] LIM_TWO   = 16'h0800;
	localparam logic [7:0]  QMARK     = 8'h3F;
	localparam logic [7:0]  LEAD_TWO  = 8'hC0;
	localparam logic [7:0]  LEAD_THR  = 8'hE0;
	localparam logic [7:0]  CONT      = 8'h80;

	// one classified unit: up to three bytes, cnt results (1..3)
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		logic       has;
		logic       last;
	} u2u8_entry_t;

endpackage

// ===== design/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// u2u8_front
// Stream parser: tracks count and unit bytes, classifies each finished unit.
// ----------------------------------------------------------------------------
module u2u8_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  q_ready,
	output logic                  push,
	output u2u8_pkg::u2u8_entry_t push_entry
);

	localparam logic [1:0] PH_LEN_HI  = 2'd0;
	localparam logic [1:0] PH_LEN_LO  = 2'd1;
	localparam logic [1:0] PH_UNIT_HI = 2'd2;
	localparam logic [1:0] PH_UNIT_LO = 2'd3;

	logic [1:0]  phase_q;
	logic [15:0] units_left_q;
	logic [7:0]  held_q;
	logic        accept;
	logic [15:0] word;
	logic        last_unit;
	u2u8_pkg::u2u8_entry_t enc;

	assign s_tready  = q_ready;
	assign accept    = s_tvalid && q_ready;
	assign word      = {held_q, s_tdata};
	assign last_unit = (units_left_q == 16'd1);

	always_comb begin
		enc      = '0;
		enc.last = last_unit;
		if (word == u2u8_pkg::UNIT_REPL) begin
			enc.b0  = u2u8_pkg::QMARK;
			enc.cnt = 2'd1;
			enc.has = 1'b1;
		end else if (word < u2u8_pkg::LIM_ONE) begin
			enc.b0  = word[7:0];
			enc.cnt = 2'd1;
			enc.has = 1'b1;
		end else if (word < u2u8_pkg::LIM_TWO) begin
			enc.b0  = u2u8_pkg::LEAD_TWO | {3'b000, word[10:6]};
			enc.b1  = u2u8_pkg::CONT | {2'b00, word[5:0]};
			enc.cnt = 2'd2;
			enc.has = 1'b1;
		end else if (word != u2u8_pkg::UNIT_NONE) begin
			enc.b0  = u2u8_pkg::LEAD_THR | {4'b0000, word[15:12]};
			enc.b1  = u2u8_pkg::CONT | {2'b00, word[11:6]};
			enc.b2  = u2u8_pkg::CONT | {2'b00, word[5:0]};
			enc.cnt = 2'd3;
			enc.has = 1'b1;
		end else begin
			enc.cnt = 2'd1;
		end
	end

	always_comb begin
		push       = 1'b0;
		push_entry = enc;
		unique case (phase_q)
			PH_LEN_LO: begin
				push_entry      = '0;
				push_entry.cnt  = 2'd1;
				push_entry.last = 1'b1;
				push            = accept && (word == 16'd0);
			end
			PH_UNIT_LO: begin
				push = accept && (enc.has || last_unit);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEN_HI;
			units_left_q <= '0;
			held_q       <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LEN_HI: begin
					held_q  <= s_tdata;
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					units_left_q <= word;
					phase_q      <= (word == 16'd0) ? PH_LEN_HI : PH_UNIT_HI;
				end
				PH_UNIT_HI: begin
					held_q  <= s_tdata;
					phase_q <= PH_UNIT_LO;
				end
				PH_UNIT_LO: begin
					units_left_q <= units_left_q - 16'd1;
					phase_q      <= last_unit ? PH_LEN_HI : PH_UNIT_HI;
				end
				default: begin
					phase_q <= PH_LEN_HI;
				end
			endcase
		end
	end

endmodule

// ===== design/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// u2u8_queue
// Small FIFO of classified units between parser and serializer.
// ----------------------------------------------------------------------------
module u2u8_queue #(
	parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u2u8_pkg::u2u8_entry_t push_entry,
	output logic                  in_ready,
	input  logic                  pop,
	output logic                  out_valid,
	output u2u8_pkg::u2u8_entry_t out_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	u2u8_pkg::u2u8_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign in_ready  = (count_q != FULL_CNT);
	assign out_valid = (count_q != '0);
	assign out_entry = mem_q[rd_ptr_q];
	assign do_push   = push && in_ready;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// u2u8_back
// Serializer: emits the bytes of each queued unit through an output register.
// ----------------------------------------------------------------------------
module u2u8_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  u2u8_pkg::u2u8_entry_t q_entry,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);

	logic [1:0] idx_q;
	logic       m_tvalid_q;
	logic [7:0] data_q;
	logic       user_q;
	logic       last_q;
	logic       load;
	logic       final_byte;
	logic [7:0] sel_byte;

	assign load       = q_valid && (!m_tvalid_q || m_tready);
	assign final_byte = (idx_q == (q_entry.cnt - 2'd1));
	assign pop        = load && final_byte;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = q_entry.b0;
			2'd1:    sel_byte = q_entry.b1;
			2'd2:    sel_byte = q_entry.b2;
			default: sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= sel_byte;
			user_q <= q_entry.has;
			last_q <= q_entry.last && final_byte;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

// ===== design/ucs2_string_to_utf8_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ucs2_string_to_utf8_decoder_core
// Transcodes length-prefixed big-endian UCS-2 strings into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input stream (s_*): one byte per transfer, a 16-bit big-endian unit count
// followed by that many big-endian 16-bit units.
// Output stream (m_*): one UTF-8 byte per transfer; tuser=1 when the byte is
// real, tuser=0 for a marker-only transfer (tdata 0). tlast marks the final
// transfer of each string; an empty string gives a single marker with tlast.
// Unit 0xFFFD becomes '?', 0xFFFF gives nothing (marker if it ends a string).
// The first byte of a unit is registered in the unit queue and then in the
// output register before it is valid on m_*.
// Throughput: one input byte per cycle while the unit queue has room; the
// serializer sends one byte per cycle while m_tready allows, through the
// single output register.
// Reset clears parser phase, queue and output valid; no transfer is pending.
// When m_tready is low the output holds and the queue fills; s_tready drops
// once the QUEUE_DEPTH entries are taken.
// ----------------------------------------------------------------------------
module ucs2_string_to_utf8_decoder_core #(
	parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] has_byte
	output logic       m_tlast
);

	logic                  push;
	logic                  q_ready;
	logic                  q_valid;
	logic                  pop;
	u2u8_pkg::u2u8_entry_t push_entry;
	u2u8_pkg::u2u8_entry_t q_entry;

	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.in_ready   (q_ready),
		.pop        (pop),
		.out_valid  (q_valid),
		.out_entry  (q_entry)
	);

	u2u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== design/u2u8_checker.sv =====
// ----------------------------------------------------------------------------
// u2u8_checker
// Port-level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ucs2_string_to_utf8_decoder_core_assert.svh"

module u2u8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// stalled output transfer keeps its payload
	`U2U8_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// marker-only transfers carry zero data
	`U2U8_ASSERT_NOW(a_marker_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 8'h00)

	// marker-only transfers always end a string
	`U2U8_ASSERT_NOW(a_marker_last, clk, arst_n, m_tvalid && !m_tuser, m_tlast)

	// no four-byte lead or invalid byte is ever produced
	`U2U8_ASSERT_NOW(a_no_f_byte, clk, arst_n, m_tvalid && m_tuser, m_tdata[7:4] != 4'hF)

endmodule

bind ucs2_string_to_utf8_decoder_core u2u8_checker u_u2u8_checker (.*);
